>>> rtl/sba_pkg.sv
// Shared types, constants and class helper functions for the slab bitmap allocator.
package sba_pkg;

    localparam int NUM_CLASSES = 9;
    localparam int MAX_PAGES   = 64;
    localparam int CLS_W       = 4;
    localparam int PG_W        = 6;
    localparam int WRD_W       = 3;
    localparam int BM_DEPTH    = NUM_CLASSES * MAX_PAGES * 8;
    localparam int FR_DEPTH    = NUM_CLASSES * MAX_PAGES;
    localparam int BM_AW       = CLS_W + PG_W + WRD_W;
    localparam int FR_AW       = CLS_W + PG_W;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_NO_PAGES  = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_INIT,
        S_FREE_RD,
        S_FREE_CMP,
        S_FREE_BM,
        S_OUT
    } t_state;

    function automatic logic [9:0] slots_per_page(input logic [CLS_W-1:0] c);
        return 10'(13'd4096 >> (4'd3 + c));
    endfunction

    function automatic logic [WRD_W-1:0] last_word(input logic [CLS_W-1:0] c);
        logic [3:0] n;
        n = (c <= 4'd3) ? 4'(4'd8 >> c) : 4'd1;
        return WRD_W'(n - 4'd1);
    endfunction

    function automatic logic [63:0] valid_mask(input logic [CLS_W-1:0] c);
        if (c <= 4'd3) begin
            return '1;
        end
        return (64'd1 << slots_per_page(c)) - 64'd1;
    endfunction

    function automatic logic [63:0] pad_word(input logic [CLS_W-1:0] c);
        if (slots_per_page(c) >= 10'd8) begin
            return '0;
        end
        return 64'hFF & ~((64'd1 << slots_per_page(c)) - 64'd1);
    endfunction

    function automatic logic [11:0] class_last(input logic [CLS_W-1:0] c);
        return 12'(13'd4096 - (13'd8 << c));
    endfunction

endpackage

>>> rtl/slab_bitmap_allocator.sv
// Slab bitmap allocator top level: class state, bitmap and frame memories, control.
// An allocation that finds free space reads bitmap words in page and word order, each
// word read in S_ALLOC_RD and checked in S_ALLOC_CHK; an allocation that takes a new
// page initializes that page's eight bitmap words in S_INIT, and an oversize or
// out-of-pages request goes straight to S_OUT. A free walks the page frame memory page
// by page and class by class (S_FREE_RD, S_FREE_CMP), then does a read-modify-write of
// one bitmap word (S_FREE_BM). The bitmap and frame memories have registered reads. No
// clearing pass is needed after reset: a page's bitmap words are written when the page
// is taken.
module slab_bitmap_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // Fields from bit 0: request_size[11:0], free_address[43:12], new_page_frame[63:44].
    input  logic [63:0] i_s_axis_tdata,
    // Fields from bit 0: action.
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // Fields from bit 0: object_address[31:0].
    output logic [31:0] o_m_axis_tdata,
    // Fields from bit 0: took_new_page[0], status[2:1].
    output logic [2:0]  o_m_axis_tuser
);
    import sba_pkg::*;

    logic [63:0] mem_bm [BM_DEPTH];
    logic [19:0] mem_fr [FR_DEPTH];

    t_state r_state, n_state;
    logic [CLS_W-1:0] r_cls, n_cls;
    logic [PG_W:0]    r_pg, n_pg;
    logic [WRD_W-1:0] r_w, n_w;
    logic [5:0]       r_s, n_s;
    logic [31:0]      r_addr, n_addr;
    logic [6:0]       r_pages [NUM_CLASSES];
    logic [6:0]       n_pages [NUM_CLASSES];
    logic [9:0]       r_free [NUM_CLASSES];
    logic [9:0]       n_free [NUM_CLASSES];
    logic [31:0]      r_res_addr, n_res_addr;
    logic             r_res_took, n_res_took;
    logic [1:0]       r_res_status, n_res_status;
    logic             r_out_valid, n_out_valid;
    logic [31:0]      r_out_addr, n_out_addr;
    logic             r_out_took, n_out_took;
    logic [1:0]       r_out_status, n_out_status;
    logic [63:0]      r_bm_rd;
    logic [19:0]      r_fr_rd;

    logic             accept, out_free;
    logic [11:0]      in_size;
    logic [31:0]      in_addr;
    logic [19:0]      in_frame;
    logic [CLS_W-1:0] in_cls;
    logic             too_large;
    logic [63:0]      masked;
    logic             bm_full;
    logic [5:0]       zero_idx;
    logic             fr_hit;
    logic [8:0]       fr_slot;
    logic             pg_valid;
    logic             pg_last;

    logic             bm_we;
    logic [BM_AW-1:0] bm_raddr, bm_waddr;
    logic [63:0]      bm_wdata;
    logic             fr_we;
    logic [FR_AW-1:0] fr_raddr, fr_waddr;

    assign accept   = i_s_axis_tvalid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign in_size  = i_s_axis_tdata[11:0];
    assign in_addr  = i_s_axis_tdata[43:12];
    assign in_frame = i_s_axis_tdata[63:44];
    assign too_large = in_size > 12'd2048;

    always_comb begin
        in_cls = CLS_W'(NUM_CLASSES - 1);
        for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
            if ({1'b0, in_size} <= (13'd8 << i)) begin
                in_cls = CLS_W'(i);
            end
        end
    end

    assign masked  = r_bm_rd | ~valid_mask(r_cls);
    assign bm_full = &masked;

    always_comb begin
        zero_idx = '0;
        for (int i = 63; i >= 0; i--) begin
            if (!masked[i]) begin
                zero_idx = 6'(i);
            end
        end
    end

    assign fr_slot  = 9'(r_addr[11:0] >> (4'd3 + r_cls));
    assign fr_hit   = (r_fr_rd == r_addr[31:12]) && (r_addr[11:0] <= class_last(r_cls));
    assign pg_valid = r_pg < r_pages[r_cls];
    assign pg_last  = (r_pg + 7'd1) >= r_pages[r_cls];

    assign fr_raddr = {r_cls, r_pg[PG_W-1:0]};
    assign bm_raddr = (r_state == S_FREE_CMP) ? {r_cls, r_pg[PG_W-1:0], fr_slot[8:6]}
                                              : {r_cls, r_pg[PG_W-1:0], r_w};
    assign bm_waddr = {r_cls, r_pg[PG_W-1:0], r_w};
    assign fr_waddr = {in_cls, r_pages[in_cls][PG_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (bm_we) begin
            mem_bm[bm_waddr] <= bm_wdata;
        end
        r_bm_rd <= mem_bm[bm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (fr_we) begin
            mem_fr[fr_waddr] <= in_frame;
        end
        r_fr_rd <= mem_fr[fr_raddr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_s_axis_tuser) begin
                        n_state = S_FREE_RD;
                    end else if (too_large) begin
                        n_state = S_OUT;
                    end else if (r_free[in_cls] == 10'd0) begin
                        n_state = (r_pages[in_cls] == 7'(MAX_PAGES)) ? S_OUT : S_INIT;
                    end else begin
                        n_state = S_ALLOC_RD;
                    end
                end
            end
            S_ALLOC_RD: n_state = S_ALLOC_CHK;
            S_ALLOC_CHK: begin
                if (!bm_full) begin
                    n_state = S_OUT;
                end else if (r_w == last_word(r_cls) && pg_last) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_ALLOC_RD;
                end
            end
            S_INIT: begin
                if (r_w == WRD_W'(7)) begin
                    n_state = S_OUT;
                end
            end
            S_FREE_RD: begin
                if (pg_valid) begin
                    n_state = S_FREE_CMP;
                end else if (r_cls == CLS_W'(NUM_CLASSES - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_FREE_CMP: n_state = fr_hit ? S_FREE_BM : S_FREE_RD;
            S_FREE_BM:  n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cls        = r_cls;
        n_pg         = r_pg;
        n_w          = r_w;
        n_s          = r_s;
        n_addr       = r_addr;
        n_pages      = r_pages;
        n_free       = r_free;
        n_res_addr   = r_res_addr;
        n_res_took   = r_res_took;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_addr   = r_out_addr;
        n_out_took   = r_out_took;
        n_out_status = r_out_status;
        bm_we        = 1'b0;
        bm_wdata     = r_bm_rd;
        fr_we        = 1'b0;
        o_s_axis_tready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_addr       = in_addr;
                    n_pg         = '0;
                    n_w          = '0;
                    n_res_addr   = '0;
                    n_res_took   = 1'b0;
                    n_res_status = ST_OK;
                    if (i_s_axis_tuser) begin
                        n_cls = '0;
                    end else if (too_large) begin
                        n_res_status = ST_TOO_LARGE;
                    end else begin
                        n_cls = in_cls;
                        if (r_free[in_cls] == 10'd0) begin
                            if (r_pages[in_cls] == 7'(MAX_PAGES)) begin
                                n_res_status = ST_NO_PAGES;
                            end else begin
                                fr_we           = 1'b1;
                                n_pg            = r_pages[in_cls];
                                n_pages[in_cls] = r_pages[in_cls] + 7'd1;
                                n_free[in_cls]  = slots_per_page(in_cls) - 10'd1;
                                n_res_addr      = {in_frame, 12'd0};
                                n_res_took      = 1'b1;
                            end
                        end
                    end
                end
            end
            S_ALLOC_CHK: begin
                if (!bm_full) begin
                    bm_we         = 1'b1;
                    bm_wdata      = r_bm_rd | (64'd1 << zero_idx);
                    n_free[r_cls] = r_free[r_cls] - 10'd1;
                    n_res_addr    = {r_fr_rd, 12'(12'({r_w, zero_idx}) << (4'd3 + r_cls))};
                end else if (r_w == last_word(r_cls)) begin
                    n_w  = '0;
                    n_pg = r_pg + 7'd1;
                    if (pg_last) begin
                        n_res_status = ST_NO_PAGES;
                    end
                end else begin
                    n_w = r_w + WRD_W'(1);
                end
            end
            S_INIT: begin
                bm_we    = 1'b1;
                bm_wdata = (r_w == '0) ? (pad_word(r_cls) | 64'd1) : 64'd0;
                n_w      = r_w + WRD_W'(1);
            end
            S_FREE_RD: begin
                if (!pg_valid) begin
                    if (r_cls == CLS_W'(NUM_CLASSES - 1)) begin
                        n_res_status = ST_NOT_FOUND;
                    end else begin
                        n_cls = r_cls + CLS_W'(1);
                        n_pg  = '0;
                    end
                end
            end
            S_FREE_CMP: begin
                if (fr_hit) begin
                    n_w = fr_slot[8:6];
                    n_s = fr_slot[5:0];
                end else begin
                    n_pg = r_pg + 7'd1;
                end
            end
            S_FREE_BM: begin
                if (!r_bm_rd[r_s]) begin
                    n_res_status = ST_NOT_FOUND;
                end else begin
                    bm_we         = 1'b1;
                    bm_wdata      = r_bm_rd & ~(64'd1 << r_s);
                    n_free[r_cls] = r_free[r_cls] + 10'd1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = r_res_addr;
                    n_out_took   = r_res_took;
                    n_out_status = r_res_status;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_pages[i] <= '0;
                r_free[i]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pages     <= n_pages;
            r_free      <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls        <= n_cls;
        r_pg         <= n_pg;
        r_w          <= n_w;
        r_s          <= n_s;
        r_addr       <= n_addr;
        r_res_addr   <= n_res_addr;
        r_res_took   <= n_res_took;
        r_res_status <= n_res_status;
        r_out_addr   <= n_out_addr;
        r_out_took   <= n_out_took;
        r_out_status <= n_out_status;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_addr;
    assign o_m_axis_tuser  = {r_out_status, r_out_took};

endmodule

>>> sim/slab_bitmap_allocator_tb.sv
// Self-checking testbench for the slab bitmap allocator, with its own model of class state.
module slab_bitmap_allocator_tb;
    import sba_pkg::*;

    localparam bit ACT_ALLOC = 1'b0;
    localparam bit ACT_FREE  = 1'b1;

    typedef struct packed {
        logic [31:0] obj_addr;
        logic        took_page;
        logic [1:0]  status;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tuser = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;
    logic [2:0]  o_m_axis_tuser;

    logic [511:0] slot_map [NUM_CLASSES][MAX_PAGES];
    logic [19:0]  frame_of [NUM_CLASSES][MAX_PAGES];
    int           page_count [NUM_CLASSES];
    int           free_count [NUM_CLASSES];

    t_outcome     outcome_q [$];
    logic [31:0]  live_objs [$];
    int           quiet = 0;
    int           hold_asked = 0;
    int           hold_given = 0;
    int           stall_left = 0;
    bit           failed = 1'b0;

    slab_bitmap_allocator dut (.*);

    always #2 i_clk = ~i_clk;

    function automatic t_outcome model_alloc(logic [11:0] sz, logic [19:0] frame);
        t_outcome r;
        int c;
        int per;
        r = '0;
        c = 0;
        while (c < NUM_CLASSES && int'(sz) > (8 << c)) c++;
        if (c >= NUM_CLASSES) begin
            r.status = ST_TOO_LARGE;
            return r;
        end
        per = 4096 >> (3 + c);
        if (free_count[c] == 0) begin
            if (page_count[c] >= MAX_PAGES) begin
                r.status = ST_NO_PAGES;
                return r;
            end
            frame_of[c][page_count[c]] = frame;
            slot_map[c][page_count[c]][0] = 1'b1;
            page_count[c]++;
            free_count[c] = per - 1;
            r.obj_addr = {frame, 12'b0};
            r.took_page = 1'b1;
            r.status = ST_OK;
            return r;
        end
        for (int p = 0; p < page_count[c]; p++) begin
            for (int s = 0; s < per; s++) begin
                if (!slot_map[c][p][s]) begin
                    slot_map[c][p][s] = 1'b1;
                    free_count[c]--;
                    r.obj_addr = {frame_of[c][p], 12'b0} + 32'(s * (8 << c));
                    r.status = ST_OK;
                    return r;
                end
            end
        end
        r.status = ST_NO_PAGES;
        return r;
    endfunction

    function automatic t_outcome model_free(logic [31:0] addr);
        t_outcome r;
        logic [31:0] base;
        int sz;
        int s;
        r = '0;
        r.status = ST_NOT_FOUND;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            sz = 8 << c;
            for (int p = 0; p < page_count[c]; p++) begin
                base = {frame_of[c][p], 12'b0};
                if (addr < base || (addr - base) > 32'(4096 - sz)) continue;
                s = int'((addr - base) / sz);
                if (slot_map[c][p][s]) begin
                    slot_map[c][p][s] = 1'b0;
                    free_count[c]++;
                    r.status = ST_OK;
                end
                return r;
            end
        end
        return r;
    endfunction

    task automatic send_item(bit act, logic [11:0] sz, logic [31:0] addr, logic [19:0] frame);
        t_outcome r;
        int idx;
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {frame, addr, sz};
        i_s_axis_tuser <= act;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (act == ACT_FREE) begin
            r = model_free(addr);
            for (idx = 0; idx < live_objs.size(); idx++) begin
                if (live_objs[idx] == addr) begin
                    live_objs.delete(idx);
                    break;
                end
            end
        end else begin
            r = model_alloc(sz, frame);
            if (r.status == ST_OK) live_objs.push_back(r.obj_addr);
        end
        outcome_q.push_back(r);
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (outcome_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    failed = 1'b1;
                end else begin
                    e = outcome_q.pop_front();
                    if (o_m_axis_tdata !== e.obj_addr) begin
                        $error("object_address expected %h got %h", e.obj_addr, o_m_axis_tdata);
                        failed = 1'b1;
                    end
                    if (o_m_axis_tuser[0] !== e.took_page) begin
                        $error("took_new_page expected %b got %b", e.took_page,
                               o_m_axis_tuser[0]);
                        failed = 1'b1;
                    end
                    if (o_m_axis_tuser[2:1] !== e.status) begin
                        $error("status expected %0d got %0d", e.status, o_m_axis_tuser[2:1]);
                        failed = 1'b1;
                    end
                end
                stall_left = quiet ? 0 : $urandom_range(0, 10);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            if (hold_given != hold_asked) begin
                hold_given = hold_asked;
                stall_left = 400;
            end
        end
        i_m_axis_tready <= i_rst_n && stall_left == 0;
    end

    task automatic test_sizes();
        logic [11:0] sizes [14] = '{0, 1, 8, 9, 16, 17, 64, 256, 513, 1024, 1025, 2048,
                                    2049, 4095};
        foreach (sizes[i]) send_item(ACT_ALLOC, sizes[i], 32'hFFFF_FFFF,
                                     (i % 2) ? 20'hFFFFF : 20'h00000);
        send_item(ACT_ALLOC, 12'd8, 32'h0, 20'h12345);
    endtask

    task automatic test_frees();
        logic [31:0] a;
        send_item(ACT_FREE, 12'hFFF, 32'hFFFF_FFFF, 20'hFFFFF);
        send_item(ACT_FREE, 12'h000, 32'h0000_0000, 20'h00000);
        a = live_objs[0];
        send_item(ACT_FREE, 12'd0, a + 32'd3, 20'd0);
        send_item(ACT_FREE, 12'd0, a, 20'd0);
        send_item(ACT_ALLOC, 12'd5, 32'd0, 20'h55555);
    endtask

    task automatic test_out_of_pages();
        repeat (132) send_item(ACT_ALLOC, 12'd2048, $urandom, 20'($urandom));
        repeat (3) send_item(ACT_FREE, 12'd0, live_objs[$urandom_range(0, live_objs.size() - 1)],
                             20'd0);
        repeat (4) send_item(ACT_ALLOC, 12'd1500, $urandom, 20'($urandom));
    endtask

    task automatic test_backpressure();
        quiet = 1;
        hold_asked++;
        repeat (12) send_item(ACT_ALLOC, 12'($urandom_range(0, 300)), $urandom, 20'($urandom));
        quiet = 0;
    endtask

    task automatic test_random(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            quiet = (i % 150) >= 120;
            r = $urandom_range(0, 99);
            if (r < 45)
                send_item(ACT_ALLOC, 12'($urandom_range(0, 8 << $urandom_range(0, 8))),
                          $urandom, 20'($urandom));
            else if (r < 85 && live_objs.size() > 0)
                send_item(ACT_FREE, 12'($urandom),
                          live_objs[$urandom_range(0, live_objs.size() - 1)], 20'($urandom));
            else if (r < 92)
                send_item(ACT_FREE, 12'($urandom), $urandom, 20'($urandom));
            else
                send_item(ACT_ALLOC, 12'($urandom), $urandom, 20'($urandom));
        end
        quiet = 0;
    endtask

    initial begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            page_count[c] = 0;
            free_count[c] = 0;
            for (int p = 0; p < MAX_PAGES; p++) begin
                slot_map[c][p] = '0;
                frame_of[c][p] = '0;
                for (int s = 4096 >> (3 + c); s < 8; s++) slot_map[c][p][s] = 1'b1;
            end
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_sizes();
        test_frees();
        test_out_of_pages();
        test_backpressure();
        test_random(880);
        i_s_axis_tvalid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (!failed && outcome_q.size() == 0) begin
            $display("[slab_bitmap_allocator] OK");
        end else begin
            $display("[slab_bitmap_allocator] ERROR");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("[slab_bitmap_allocator] ERROR");
        $finish;
    end

endmodule
